/* sv/rpig_pkg.sv */
// rpig_pkg: shared types, constants and state encodings of the Rader index generator
// no dependencies; imported by the interface users and every module of the block
package rpig_pkg;

  // index and modulus width of the datapath
  localparam int IDX_W   = 11;
  // distinct prime factors of p-1 for p below 2048 (2*3*5*7 = 210, *11 = 2310)
  localparam int FACS_N  = 4;
  localparam int FAC_W   = 2;
  localparam int NF_W    = 3;
  // trial divisor never passes 46
  localparam int Z_W     = 6;
  // step counter of the shift-subtract unit
  localparam int STEP_W  = 4;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t ONE        = idx_t'(1);
  localparam idx_t FIRST_CAND = idx_t'(2);
  localparam idx_t MIN_PRIME  = idx_t'(3);
  localparam idx_t RESET_LEN  = idx_t'(3);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IDX_W - 1);

  // request and result payloads
  typedef struct packed {
    idx_t seq_index;
  } req_t;

  typedef struct packed {
    idx_t fwd_index;
    idx_t inv_index;
    idx_t gen_root;
    logic root_ok;
  } rsp_t;

  // shift-subtract unit: (a*b) mod m and floor(a*b/m) for a == 1
  typedef struct packed {
    logic start;
    idx_t a;
    idx_t b;
    idx_t m;
  } mu_req_t;

  typedef struct packed {
    logic done;
    idx_t rem;
    idx_t quo;
  } mu_rsp_t;

  // exponent sequencer commands
  typedef enum logic {
    PW_OP_POW,
    PW_OP_DIV
  } pw_op_e;

  typedef struct packed {
    logic   start;
    pw_op_e op;
    idx_t   x;
    idx_t   y;
    idx_t   m;
  } pw_req_t;

  typedef struct packed {
    logic done;
    idx_t res;
    idx_t quo;
  } pw_rsp_t;

  typedef enum logic [2:0] {
    PW_IDLE,
    PW_CHECK,
    PW_MUL,
    PW_SQ,
    PW_DIV
  } pw_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FTEST,
    ST_FDIV,
    ST_EXPS,
    ST_EDIV,
    ST_RTRY,
    ST_RFERM,
    ST_RORD,
    ST_RORDW,
    ST_RINV,
    ST_SERVE,
    ST_FWDW,
    ST_INVW,
    ST_DONE
  } top_state_e;

endpackage

/* sv/rpig_stream_if.sv */
// rpig_stream_if: valid/ready channel carrying one payload of a given type
// no dependencies; the payload type is set where the channel is instantiated
interface rpig_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* sv/rpig_modunit.sv */
// rpig_modunit: shared shift-subtract unit, one multiplier bit per cycle
// depends on rpig_pkg; computes (a*b) mod m, and the quotient when a is one
module rpig_modunit
  import rpig_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mu_req_t req_i,
  output mu_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  idx_t              a_q, b_q, m_q, r_q, q_q;

  logic [IDX_W+1:0] t_sum;
  logic [IDX_W+1:0] m1;
  logic [IDX_W+1:0] m2;
  logic [IDX_W+1:0] t_red;
  logic             q_bit;

  // one step: double, add the addend, reduce by at most twice the modulus
  always_comb begin
    m1    = {2'b00, m_q};
    m2    = {1'b0, m_q, 1'b0};
    t_sum = {1'b0, r_q, 1'b0} + (b_q[IDX_W-1] ? {2'b00, a_q} : '0);
    q_bit = (t_sum >= m1);
    if (t_sum >= m2) begin
      t_red = t_sum - m2;
    end else if (t_sum >= m1) begin
      t_red = t_sum - m1;
    end else begin
      t_red = t_sum;
    end
  end

  // step register and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      a_q    <= '0;
      b_q    <= '0;
      m_q    <= '0;
      r_q    <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        m_q    <= req_i.m;
        r_q    <= '0;
        q_q    <= '0;
      end else if (busy_q) begin
        r_q    <= t_red[IDX_W-1:0];
        q_q    <= {q_q[IDX_W-2:0], q_bit};
        b_q    <= {b_q[IDX_W-2:0], 1'b0};
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q;
  assign rsp_o.quo  = q_q;

endmodule

/* sv/rpig_pow.sv */
// rpig_pow: square-and-multiply sequencer over the shared shift-subtract unit
// depends on rpig_pkg and rpig_modunit; also passes single divisions to the unit
module rpig_pow
  import rpig_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pw_req_t req_i,
  output pw_rsp_t rsp_o
);

  pw_state_e state_q, state_d;
  idx_t      acc_q, acc_d;
  idx_t      base_q, base_d;
  idx_t      e_q, e_d;
  idx_t      m_q, m_d;
  logic      done_q, done_d;
  idx_t      res_q, res_d;
  idx_t      quo_q, quo_d;

  mu_req_t mu_req;
  mu_rsp_t mu_rsp;

  rpig_modunit u_modunit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mu_req),
    .rsp_o  (mu_rsp)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PW_IDLE;
      done_q  <= 1'b0;
      acc_q   <= '0;
      base_q  <= '0;
      e_q     <= '0;
      m_q     <= '0;
      res_q   <= '0;
      quo_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      e_q     <= e_d;
      m_q     <= m_d;
      res_q   <= res_d;
      quo_q   <= quo_d;
    end
  end

  // next state and unit requests
  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    base_d       = base_q;
    e_d          = e_q;
    m_d          = m_q;
    done_d       = 1'b0;
    res_d        = res_q;
    quo_d        = quo_q;
    mu_req.start = 1'b0;
    mu_req.a     = '0;
    mu_req.b     = '0;
    mu_req.m     = m_q;

    case (state_q)
      PW_IDLE: begin
        if (req_i.start) begin
          m_d = req_i.m;
          if (req_i.op == PW_OP_DIV) begin
            mu_req.start = 1'b1;
            mu_req.a     = ONE;
            mu_req.b     = req_i.x;
            mu_req.m     = req_i.m;
            state_d      = PW_DIV;
          end else begin
            acc_d   = ONE;
            base_d  = req_i.x;
            e_d     = req_i.y;
            state_d = PW_CHECK;
          end
        end
      end
      PW_CHECK: begin
        if (e_q == '0) begin
          done_d  = 1'b1;
          res_d   = acc_q;
          state_d = PW_IDLE;
        end else if (e_q[0]) begin
          mu_req.start = 1'b1;
          mu_req.a     = acc_q;
          mu_req.b     = base_q;
          state_d      = PW_MUL;
        end else begin
          mu_req.start = 1'b1;
          mu_req.a     = base_q;
          mu_req.b     = base_q;
          state_d      = PW_SQ;
        end
      end
      PW_MUL: begin
        if (mu_rsp.done) begin
          acc_d = mu_rsp.rem;
          if (e_q == ONE) begin
            // last exponent bit: no square needed
            e_d     = '0;
            state_d = PW_CHECK;
          end else begin
            mu_req.start = 1'b1;
            mu_req.a     = base_q;
            mu_req.b     = base_q;
            state_d      = PW_SQ;
          end
        end
      end
      PW_SQ: begin
        if (mu_rsp.done) begin
          base_d  = mu_rsp.rem;
          e_d     = {1'b0, e_q[IDX_W-1:1]};
          state_d = PW_CHECK;
        end
      end
      PW_DIV: begin
        if (mu_rsp.done) begin
          done_d  = 1'b1;
          res_d   = mu_rsp.rem;
          quo_d   = mu_rsp.quo;
          state_d = PW_IDLE;
        end
      end
      default: begin
        state_d = PW_IDLE;
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* sv/rader_permutation_index_gen_top.sv */
// rader_permutation_index_gen_top: root search, caching and request sequencing
// depends on rpig_pkg, rpig_stream_if and rpig_pow (which holds rpig_modunit)
//
//  channel  dir  handshake          payload
//  req      in   valid / ready      seq_index
//  rsp      out  valid / ready      fwd_index, inv_index, gen_root, root_ok
//  cfg      in   cfg_we_i           cfg_wdata_i (prime_len)
//
// every modular multiply and every division runs on one shift-subtract unit,
// one operand bit per cycle. a request on a cached root takes two
// exponentiations of up to 21 unit operations each; one request at a time.
// the first request after reset or a prime_len write also factors p-1 and
// tries candidates 2..p-1.
// reset sets prime_len to 3 and drops the cache; rsp is held in an output
// register, so the next request is taken while a result waits for ready.
module rader_permutation_index_gen_top
  import rpig_pkg::*;
#(
  parameter int MAX_PRIME = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rpig_stream_if.sink         req,
  rpig_stream_if.source       rsp,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_wdata_i
);

  localparam int               LIM_W   = IDX_W + 2;
  localparam logic [LIM_W-1:0] MAX_LEN = LIM_W'(MAX_PRIME);

  top_state_e      state_q, state_d;
  idx_t            prime_q, prime_d;
  idx_t            root_q, root_d;
  idx_t            inv_q, inv_d;
  logic            cache_valid_q, cache_valid_d;
  logic            root_exists_q, root_exists_d;
  idx_t            idx_q, idx_d;
  idx_t            rem_q, rem_d;
  logic [Z_W-1:0]  z_q, z_d;
  logic [NF_W-1:0] nf_q, nf_d;
  logic [NF_W-1:0] k_q, k_d;
  idx_t            facs_q [FACS_N];
  idx_t            facs_d [FACS_N];
  idx_t            exps_q [FACS_N];
  idx_t            exps_d [FACS_N];
  idx_t            cand_q, cand_d;
  idx_t            fwd_q, fwd_d;
  idx_t            invi_q, invi_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  pw_req_t pw_req;
  pw_rsp_t pw_rsp;

  logic [2*Z_W-1:0] z_sq;
  idx_t             last_fac;
  idx_t             z_ext;
  logic             bad_len;

  rpig_pow u_pow (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pw_req),
    .rsp_o  (pw_rsp)
  );

  assign z_sq     = z_q * z_q;
  assign z_ext    = idx_t'(z_q);
  assign last_fac = facs_q[nf_q[FAC_W-1:0] - 1'b1];
  assign bad_len  = (prime_q < MIN_PRIME) || ({2'b00, prime_q} >= MAX_LEN);

  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid = out_valid_q;
  assign rsp.data  = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      prime_q       <= RESET_LEN;
      root_q        <= '0;
      inv_q         <= '0;
      cache_valid_q <= 1'b0;
      root_exists_q <= 1'b0;
      nf_q          <= '0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      prime_q       <= prime_d;
      root_q        <= root_d;
      inv_q         <= inv_d;
      cache_valid_q <= cache_valid_d;
      root_exists_q <= root_exists_d;
      nf_q          <= nf_d;
      k_q           <= k_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    rem_q  <= rem_d;
    z_q    <= z_d;
    facs_q <= facs_d;
    exps_q <= exps_d;
    cand_q <= cand_d;
    fwd_q  <= fwd_d;
    invi_q <= invi_d;
    out_q  <= out_d;
  end

  // sequencer: on a cache miss factor p-1 and search the root, then serve the request
  always_comb begin
    state_d       = state_q;
    prime_d       = prime_q;
    root_d        = root_q;
    inv_d         = inv_q;
    cache_valid_d = cache_valid_q;
    root_exists_d = root_exists_q;
    idx_d         = idx_q;
    rem_d         = rem_q;
    z_d           = z_q;
    nf_d          = nf_q;
    k_d           = k_q;
    facs_d        = facs_q;
    exps_d        = exps_q;
    cand_d        = cand_q;
    fwd_d         = fwd_q;
    invi_d        = invi_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    pw_req.start  = 1'b0;
    pw_req.op     = PW_OP_POW;
    pw_req.x      = '0;
    pw_req.y      = '0;
    pw_req.m      = prime_q;

    // result taken downstream
    if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          idx_d   = req.data.seq_index;
          state_d = cache_valid_q ? ST_SERVE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        cache_valid_d = 1'b1;
        root_exists_d = 1'b0;
        root_d        = '0;
        inv_d         = '0;
        rem_d         = prime_q - ONE;
        z_d           = Z_W'(2);
        nf_d          = '0;
        state_d       = bad_len ? ST_SERVE : ST_FTEST;
      end
      ST_FTEST: begin
        if (z_sq <= {1'b0, rem_q}) begin
          pw_req.start = 1'b1;
          pw_req.op    = PW_OP_DIV;
          pw_req.x     = rem_q;
          pw_req.m     = z_ext;
          state_d      = ST_FDIV;
        end else begin
          // leftover cofactor is the largest prime factor
          if (rem_q > ONE && (nf_q == '0 || last_fac != rem_q)) begin
            facs_d[nf_q[FAC_W-1:0]] = rem_q;
            nf_d = nf_q + 1'b1;
          end
          k_d     = '0;
          state_d = ST_EXPS;
        end
      end
      ST_FDIV: begin
        if (pw_rsp.done) begin
          if (pw_rsp.res == '0) begin
            if (nf_q == '0 || last_fac != z_ext) begin
              facs_d[nf_q[FAC_W-1:0]] = z_ext;
              nf_d = nf_q + 1'b1;
            end
            rem_d = pw_rsp.quo;
          end else begin
            z_d = z_q + 1'b1;
          end
          state_d = ST_FTEST;
        end
      end
      ST_EXPS: begin
        if (k_q == nf_q) begin
          cand_d  = FIRST_CAND;
          state_d = ST_RTRY;
        end else begin
          pw_req.start = 1'b1;
          pw_req.op    = PW_OP_DIV;
          pw_req.x     = prime_q - ONE;
          pw_req.m     = facs_q[k_q[FAC_W-1:0]];
          state_d      = ST_EDIV;
        end
      end
      ST_EDIV: begin
        if (pw_rsp.done) begin
          exps_d[k_q[FAC_W-1:0]] = pw_rsp.quo;
          k_d     = k_q + 1'b1;
          state_d = ST_EXPS;
        end
      end
      ST_RTRY: begin
        if (cand_q == prime_q) begin
          state_d = ST_SERVE;
        end else begin
          pw_req.start = 1'b1;
          pw_req.x     = cand_q;
          pw_req.y     = prime_q - ONE;
          state_d      = ST_RFERM;
        end
      end
      ST_RFERM: begin
        if (pw_rsp.done) begin
          if (pw_rsp.res == ONE) begin
            k_d     = '0;
            state_d = ST_RORD;
          end else begin
            cand_d  = cand_q + ONE;
            state_d = ST_RTRY;
          end
        end
      end
      ST_RORD: begin
        pw_req.start = 1'b1;
        pw_req.x     = cand_q;
        if (k_q == nf_q) begin
          // order test passed: form the inverse
          pw_req.y = prime_q - FIRST_CAND;
          state_d  = ST_RINV;
        end else begin
          pw_req.y = exps_q[k_q[FAC_W-1:0]];
          state_d  = ST_RORDW;
        end
      end
      ST_RORDW: begin
        if (pw_rsp.done) begin
          if (pw_rsp.res == ONE) begin
            cand_d  = cand_q + ONE;
            state_d = ST_RTRY;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_RORD;
          end
        end
      end
      ST_RINV: begin
        if (pw_rsp.done) begin
          inv_d         = pw_rsp.res;
          root_d        = cand_q;
          root_exists_d = 1'b1;
          state_d       = ST_SERVE;
        end
      end
      ST_SERVE: begin
        if (root_exists_q) begin
          pw_req.start = 1'b1;
          pw_req.x     = root_q;
          pw_req.y     = idx_q;
          state_d      = ST_FWDW;
        end else begin
          fwd_d   = '0;
          invi_d  = '0;
          state_d = ST_DONE;
        end
      end
      ST_FWDW: begin
        if (pw_rsp.done) begin
          fwd_d        = pw_rsp.res;
          pw_req.start = 1'b1;
          pw_req.x     = inv_q;
          pw_req.y     = idx_q;
          state_d      = ST_INVW;
        end
      end
      ST_INVW: begin
        if (pw_rsp.done) begin
          invi_d  = pw_rsp.res;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          out_d.fwd_index = fwd_q;
          out_d.inv_index = invi_q;
          out_d.gen_root  = root_q;
          out_d.root_ok   = root_exists_q;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // prime_len write drops the cached root
    if (cfg_we_i) begin
      prime_d       = cfg_wdata_i;
      cache_valid_d = 1'b0;
    end
  end

  // a cached root is at least two and below the prime
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cache_valid_q && root_exists_q)
      |-> (root_q >= FIRST_CAND && root_q < prime_q))
    else $error("cached root out of range");

  // sequencer results only arrive while a wait state expects them
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw_rsp.done |-> (state_q == ST_FDIV || state_q == ST_EDIV || state_q == ST_RFERM ||
                     state_q == ST_RORDW || state_q == ST_RINV || state_q == ST_FWDW ||
                     state_q == ST_INVW))
    else $error("exponent sequencer result with no consumer");

  // a reported root always comes with a nonzero generator
  a_ok_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.data.root_ok) |-> (rsp.data.gen_root >= FIRST_CAND))
    else $error("root_ok set without a valid generator");

endmodule

/* verif/rader_perm_checker.sv */
// rader_perm_checker: watches the request, result and config ports of the index generator
// predicts every result from its own root search and square-and-multiply, compares in order
// depends on rpig_pkg; hands its failure count and open expectations to the testbench top
module rader_perm_checker
  import rpig_pkg::*;
#(
  parameter int MAX_PRIME = 2048
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_data_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_data_i,
  input  logic cfg_we_i,
  input  idx_t cfg_wdata_i,
  output int   err_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  // mirrored block state
  idx_t modulus_q;
  idx_t root_q;
  idx_t root_inv_q;
  logic root_known_q;
  logic root_found_q;

  // results still owed by the block, oldest first
  rsp_t expected_perm_q[$];
  rsp_t want;

  // base^ex mod m, m at least 3
  function automatic idx_t pow_mod_idx(idx_t base, idx_t ex, idx_t m);
    int unsigned acc;
    int unsigned b;
    int unsigned e;
    acc = 1 % m;
    b   = base % m;
    e   = ex;
    while (e != 0) begin
      if ((e & 1) != 0) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return idx_t'(acc);
  endfunction

  // factor p-1, then take the smallest candidate whose order is exactly p-1
  function automatic void find_generator();
    int unsigned p;
    int unsigned rem;
    int unsigned z;
    int unsigned nf;
    int unsigned r;
    int unsigned k;
    int unsigned facs[16];
    bit          ok;
    root_q       = '0;
    root_inv_q   = '0;
    root_found_q = 1'b0;
    root_known_q = 1'b1;
    p = modulus_q;
    if (p < MIN_PRIME || p >= MAX_PRIME) return;
    nf  = 0;
    rem = p - 1;
    z   = 2;
    // distinct prime factors by trial division
    while (z * z <= rem) begin
      if (rem % z == 0) begin
        if ((nf == 0 || facs[nf-1] != z) && nf < 16) begin
          facs[nf] = z;
          nf++;
        end
        rem = rem / z;
      end else begin
        z++;
      end
    end
    if (rem > 1 && (nf == 0 || facs[nf-1] != rem) && nf < 16) begin
      facs[nf] = rem;
      nf++;
    end
    // candidate scan
    for (r = FIRST_CAND; r < p; r++) begin
      ok = (pow_mod_idx(idx_t'(r), idx_t'(p - 1), idx_t'(p)) == ONE);
      for (k = 0; ok && k < nf; k++) begin
        if (pow_mod_idx(idx_t'(r), idx_t'((p - 1) / facs[k]), idx_t'(p)) == ONE) ok = 1'b0;
      end
      if (ok) begin
        root_q       = idx_t'(r);
        root_inv_q   = pow_mod_idx(idx_t'(r), idx_t'(p - 2), idx_t'(p));
        root_found_q = 1'b1;
        return;
      end
    end
  endfunction

  // forward and inverse permutation entry for one exponent
  function automatic rsp_t predict_perm_entry(idx_t seq);
    rsp_t res;
    res = '0;
    if (root_found_q) begin
      res.fwd_index = pow_mod_idx(root_q, seq, modulus_q);
      res.inv_index = pow_mod_idx(root_inv_q, seq, modulus_q);
      res.gen_root  = root_q;
      res.root_ok   = 1'b1;
    end
    return res;
  endfunction

  // count a failure, print only the first few
  function automatic void flag_result(string what, rsp_t exp_r, rsp_t got_r);
    err_count_o++;
    if (err_count_o <= REPORT_MAX) begin
      $display("%0t %s: exp fwd=%0d inv=%0d root=%0d ok=%0d, got fwd=%0d inv=%0d root=%0d ok=%0d",
               $realtime, what, exp_r.fwd_index, exp_r.inv_index, exp_r.gen_root,
               exp_r.root_ok, got_r.fwd_index, got_r.inv_index, got_r.gen_root,
               got_r.root_ok);
    end
  endfunction

  // result check first, so a result never matches a request taken on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    = RESET_LEN;
      root_q       = '0;
      root_inv_q   = '0;
      root_known_q = 1'b0;
      root_found_q = 1'b0;
      expected_perm_q.delete();
      err_count_o  = 0;
      pending_o    = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_perm_q.size() == 0) begin
          flag_result("unexpected result", '0, rsp_data_i);
        end else begin
          want = expected_perm_q.pop_front();
          if (want !== rsp_data_i) flag_result("result mismatch", want, rsp_data_i);
        end
      end
      // accepted request, appended at the tail
      if (req_valid_i && req_ready_i) begin
        if (!root_known_q) find_generator();
        expected_perm_q.insert(expected_perm_q.size(),
                               predict_perm_entry(req_data_i.seq_index));
      end
      // prime_len write drops the cached root
      if (cfg_we_i) begin
        modulus_q    = cfg_wdata_i;
        root_known_q = 1'b0;
      end
      pending_o = expected_perm_q.size();
    end
  end

endmodule

/* verif/tb_rader_permutation_index_gen_top.sv */
// tb_rader_permutation_index_gen_top: clock, reset, stimulus and verdict for the index generator
// depends on rpig_pkg, rpig_stream_if, rader_permutation_index_gen_top and rader_perm_checker
module tb_rader_permutation_index_gen_top
  import rpig_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 150;
  localparam int IDLE_PCT      = 6;
  localparam int SETTLE_CYCLES = 20;
  localparam int POOL_N        = 18;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  idx_t cfg_wdata;
  bit   idle_on;
  int   cycle_cnt = 0;
  int   err_count;
  int   pending;
  idx_t cur_prime;

  // primes with small and unusually large smallest roots
  idx_t prime_pool[POOL_N] = '{11'd3, 11'd5, 11'd7, 11'd13, 11'd17, 11'd23, 11'd41, 11'd71,
                               11'd97, 11'd191, 11'd257, 11'd409, 11'd641, 11'd1009,
                               11'd1151, 11'd1583, 11'd1999, 11'd2039};

  rpig_stream_if #(.payload_t(req_t)) req_ch ();
  rpig_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  rader_permutation_index_gen_top #(
    .MAX_PRIME (2048)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  rader_perm_checker #(
    .MAX_PRIME (2048)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_data_i  (req_ch.data),
    .rsp_valid_i (rsp_ch.valid),
    .rsp_ready_i (rsp_ch.ready),
    .rsp_data_i  (rsp_ch.data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_seq(input idx_t seq);
    @(negedge clk_i);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{seq_index: seq};
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // stop sending until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // prime_len write, only with the block idle
  task automatic load_prime(input idx_t p);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cur_prime = p;
  endtask

  // mostly in-range exponents, some full-width and some edge values
  function automatic idx_t pick_seq(idx_t p);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50 && p >= MIN_PRIME) return idx_t'($urandom_range(0, p - 2));
    if (sel < 85) return idx_t'($urandom_range(0, 2047));
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return idx_t'(p - 1);
      default: return '1;
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    idle_on      = 1'b1;
    cur_prime    = RESET_LEN;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset length 3, exponents past p-1 wrap
    send_seq(11'd0);
    send_seq(11'd1);
    send_seq(11'd2);
    send_seq(11'd2047);
    send_seq(11'd1024);
    // largest prime of the range
    load_prime(11'd2039);
    send_seq(11'd0);
    send_seq(11'd1);
    send_seq(11'd2037);
    send_seq(11'd2038);
    send_seq(11'd2047);
    send_seq(11'h555);
    send_seq(11'h2AA);
    // lengths below 3 give no root
    load_prime(11'd0);
    send_seq(11'd5);
    load_prime(11'd1);
    send_seq(11'd0);
    load_prime(11'd2);
    send_seq(11'd7);
    // composites: plain, base-2 pseudoprime, all-ones length
    load_prime(11'd9);
    send_seq(11'd3);
    load_prime(11'd341);
    send_seq(11'd4);
    load_prime(11'd2047);
    send_seq(11'd2047);
    send_seq(11'd1);

    // random phases, one length each; two phases run without idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = !(ph == 4 || ph == 5);
      if ($urandom_range(0, 3) == 0) load_prime(idx_t'($urandom_range(3, 127)));
      else load_prime(prime_pool[$urandom_range(0, POOL_N - 1)]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
        send_seq(pick_seq(cur_prime));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
